// ----- rtl/kcl_pkg.sv -----
// Shared types, codes and reset constants for the keypad code lock checker.
`timescale 1ns / 1ps

package kcl_pkg;

	// Largest supported code length.
	localparam int MAX_CODE_CHARS_DEF = 5;

	// Field widths.
	localparam int KEY_W = 8;
	localparam int LEN_W = 3;
	localparam int POS_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	// Special key codes.
	localparam logic [KEY_W-1:0] KEY_HASH = 8'h23;
	localparam logic [KEY_W-1:0] KEY_NONE = 8'h00;

	// Register indexes; the code characters follow the length register.
	localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_CHAR_0 = 3'd1;

	// Reset configuration: code "12345", length five.
	localparam logic [LEN_W-1:0] CODE_LEN_RESET = 3'd5;
	localparam logic [4:0][KEY_W-1:0] RESET_CODE = {8'h35, 8'h34, 8'h33, 8'h32, 8'h31};

	// Lock button machine.
	typedef enum logic [1:0] {
		LP_BEFORE = 2'd0,
		LP_START  = 2'd1,
		LP_WAIT   = 2'd2,
		LP_HELD   = 2'd3
	} lock_phase_t;

	// Code entry machine.
	typedef enum logic [2:0] {
		EP_BEFORE = 3'd0,
		EP_START  = 3'd1,
		EP_IDLE   = 3'd2,
		EP_REARM  = 3'd3,
		EP_AWAIT  = 3'd4,
		EP_DOWN   = 3'd5,
		EP_UP     = 3'd6,
		EP_DONE   = 3'd7
	} entry_phase_t;

	// One configuration write request.
	typedef struct packed {
		logic                  valid;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_req_t;

endpackage

// ----- rtl/keypad_code_lock_checker.sv -----
// A request is held in the input register, then its result is registered in the output register.
// Throughput: one request per cycle when m_axis_tready does not stall the output register.
// The input register takes a new request while a finished result waits to be taken.
// Reset (arst_n low, asynchronous) empties both registers, restores code "12345"
// with length five, and returns both state machines to their start-up phase.
`timescale 1ns / 1ps

module keypad_code_lock_checker #(
	parameter int MAX_CODE_CHARS = kcl_pkg::MAX_CODE_CHARS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // [7:0] key_char
	input  logic                              s_axis_tuser,  // [0] lock_button
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [7:0]                        m_axis_tdata,  // [0] unlocked, [7:1] zero
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [kcl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kcl_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import kcl_pkg::*;

	cfg_req_t                            cfg_req;
	logic [LEN_W-1:0]                    code_length;
	logic [MAX_CODE_CHARS-1:0][KEY_W-1:0] code_chars;

	logic             valid_s1;
	logic [KEY_W-1:0] key_s1;
	logic             button_s1;
	logic             out_valid_q;
	logic             out_unlocked_q;
	logic             advance;
	logic             unlocked_next;

	// Configuration writes are always taken.
	assign cfg_ready     = 1'b1;
	assign cfg_req.valid = cfg_valid;
	assign cfg_req.index = cfg_index;
	assign cfg_req.data  = cfg_data;

	kcl_cfg #(.MAX_CODE_CHARS(MAX_CODE_CHARS)) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (cfg_req),
		.code_length (code_length),
		.code_chars  (code_chars)
	);

	// The held request moves on when the output register is free or being emptied.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			key_s1    <= s_axis_tdata;
			button_s1 <= s_axis_tuser;
		end
	end

	kcl_fsm #(.MAX_CODE_CHARS(MAX_CODE_CHARS)) u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.key_char      (key_s1),
		.lock_button   (button_s1),
		.code_length   (code_length),
		.code_chars    (code_chars),
		.unlocked_next (unlocked_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_unlocked_q <= unlocked_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_unlocked_q};

endmodule

// ----- rtl/kcl_cfg.sv -----
// Configuration register file holding the code length and code characters.
`timescale 1ns / 1ps

module kcl_cfg #(
	parameter int MAX_CODE_CHARS = kcl_pkg::MAX_CODE_CHARS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  kcl_pkg::cfg_req_t                            req,
	output logic [kcl_pkg::LEN_W-1:0]                    code_length,
	output logic [MAX_CODE_CHARS-1:0][kcl_pkg::KEY_W-1:0] code_chars
);
	import kcl_pkg::*;

	logic [LEN_W-1:0]                    code_length_q;
	logic [MAX_CODE_CHARS-1:0][KEY_W-1:0] code_chars_q;

	// Register writes; indexes with no register behind them are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_length_q <= CODE_LEN_RESET;
			for (int i = 0; i < MAX_CODE_CHARS; i++) begin
				code_chars_q[i] <= RESET_CODE[i];
			end
		end else if (req.valid) begin
			if (req.index == REG_CODE_LENGTH) begin
				code_length_q <= req.data[LEN_W-1:0];
			end
			for (int i = 0; i < MAX_CODE_CHARS; i++) begin
				if (req.index == REG_CODE_CHAR_0 + CFG_IDX_W'(i)) begin
					code_chars_q[i] <= req.data;
				end
			end
		end
	end

	assign code_length = code_length_q;
	assign code_chars  = code_chars_q;

endmodule

// ----- rtl/kcl_fsm.sv -----
// Lock button and code entry state machines, advanced once per tick.
`timescale 1ns / 1ps

module kcl_fsm #(
	parameter int MAX_CODE_CHARS = kcl_pkg::MAX_CODE_CHARS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          step,
	input  logic [kcl_pkg::KEY_W-1:0]                     key_char,
	input  logic                                          lock_button,
	input  logic [kcl_pkg::LEN_W-1:0]                     code_length,
	input  logic [MAX_CODE_CHARS-1:0][kcl_pkg::KEY_W-1:0] code_chars,
	output logic                                          unlocked_next
);
	import kcl_pkg::*;

	lock_phase_t      lock_q, lock_n;
	entry_phase_t     entry_q, entry_n;
	logic             seen_q, seen_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic             unl_q, unl_n;

	// State registers move only when a tick is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q  <= LP_BEFORE;
			entry_q <= EP_BEFORE;
			seen_q  <= 1'b0;
			pos_q   <= '0;
			unl_q   <= 1'b0;
		end else if (step) begin
			lock_q  <= lock_n;
			entry_q <= entry_n;
			seen_q  <= seen_n;
			pos_q   <= pos_n;
			unl_q   <= unl_n;
		end
	end

	// Lock machine first, then the entry machine sees its updated flags.
	always_comb begin
		logic             unl_a;
		logic             up;
		logic [KEY_W-1:0] want;
		logic [LEN_W-1:0] eff_len;
		logic [POS_W-1:0] last;
		logic             is_none;
		logic             is_hash;

		case (lock_q)
			LP_BEFORE: lock_n = LP_START;
			LP_START:  lock_n = LP_WAIT;
			default:   lock_n = lock_button ? LP_HELD : LP_WAIT;
		endcase
		seen_n = seen_q;
		unl_a  = unl_q;
		if (lock_n == LP_WAIT) begin
			seen_n = 1'b0;
		end else if (lock_n == LP_HELD) begin
			unl_a  = 1'b0;
			seen_n = 1'b1;
		end
		up = !seen_n;

		// Expected character; positions past the stored code read as no key.
		want = KEY_NONE;
		for (int i = 0; i < MAX_CODE_CHARS; i++) begin
			if (pos_q == POS_W'(i)) begin
				want = code_chars[i];
			end
		end

		// A zero length acts as one and an oversized length is clamped.
		eff_len = code_length;
		if (eff_len == '0) begin
			eff_len = LEN_W'(1);
		end
		if (eff_len > LEN_W'(MAX_CODE_CHARS)) begin
			eff_len = LEN_W'(MAX_CODE_CHARS);
		end
		last = POS_W'(eff_len - LEN_W'(1));

		is_none = (key_char == KEY_NONE);
		is_hash = (key_char == KEY_HASH);
		pos_n   = pos_q;

		case (entry_q)
			EP_BEFORE: entry_n = EP_START;
			EP_START:  entry_n = EP_IDLE;
			EP_IDLE: begin
				entry_n = (is_hash && up && !unl_a) ? EP_REARM : EP_IDLE;
			end
			EP_REARM: begin
				entry_n = (is_hash && up) ? EP_REARM : EP_AWAIT;
			end
			EP_AWAIT: begin
				if (key_char == want && up)  entry_n = EP_DOWN;
				else if (is_none && up)      entry_n = EP_AWAIT;
				else if (is_hash && up)      entry_n = EP_REARM;
				else                         entry_n = EP_IDLE;
			end
			EP_DOWN: begin
				if (key_char == want && up)  entry_n = EP_DOWN;
				else if (is_none && up)      entry_n = EP_UP;
				else if (is_hash && up)      entry_n = EP_REARM;
				else                         entry_n = EP_IDLE;
			end
			EP_UP: begin
				if (is_none && pos_q < last && up) begin
					entry_n = EP_AWAIT;
					pos_n   = pos_q + POS_W'(1);
				end else if (is_none && pos_q == last && up) begin
					entry_n = EP_DONE;
				end else if (is_hash && up) begin
					entry_n = EP_REARM;
				end else begin
					entry_n = EP_IDLE;
				end
			end
			default: entry_n = EP_IDLE;
		endcase

		unl_n = unl_a;
		if (entry_n == EP_IDLE || entry_n == EP_REARM) begin
			pos_n = '0;
		end else if (entry_n == EP_DONE) begin
			unl_n = 1'b1;
		end
	end

	assign unlocked_next = unl_n;

endmodule

// ----- rtl/kcl_checker.sv -----
// Port-level assertions for the keypad code lock checker and their bind.
`timescale 1ns / 1ps

module kcl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       cfg_ready
);

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

	// Only the flag bit of a result may be set.
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
		else $error("result padding not zero");

	// With both registers full, a new request is taken only as the result leaves.
	a_full_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready && s_axis_tvalid && s_axis_tready)
		|=> (s_axis_tready == m_axis_tready))
		else $error("input ready wrong with both stages full");

	// Configuration writes are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind keypad_code_lock_checker kcl_checker u_kcl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_ready     (cfg_ready)
);
